/* sv/vbf_pkg.sv */
// vbf_pkg: shared types and constants for the vector bloom filter
// no dependencies
package vbf_pkg;

  localparam int HASH_W  = 32;
  localparam int SET_W   = 4;
  localparam int MATCH_W = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FIN
  } vbf_state_t;

endpackage

/* sv/vector_bloom_filter_membership.sv */
// vector_bloom_filter_membership: vector bloom filter top level
// depends on vbf_pkg and vbf_slot_ram
//
// Set membership over SLOTS slots of SETS bits, held in one memory with a
// write port and a registered read port. SLOTS must be a power of two, the
// probe address being the low bits of first_hash + j*second_hash. After
// reset the block sweeps the memory to zero, one slot a cycle, and holds
// in_stall high until the sweep is done. A request then issues one memory
// read a cycle for each probe, with add write-backs in the cycle after their
// reads, then forms the result in ST_FIN, during which the next request is
// taken once the output register is free. A rejected add skips the memory and
// goes straight to ST_FIN. The result sits in an output register, so a
// finished request waits there while the next runs.
module vector_bloom_filter_membership import vbf_pkg::*; #(
  parameter int SLOTS  = 2048,
  parameter int PROBES = 4,
  parameter int SETS   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [HASH_W-1:0]  in_first_hash,
  input  logic [HASH_W-1:0]  in_second_hash,
  input  logic [SET_W-1:0]   in_add_set,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [MATCH_W-1:0] out_match_set,
  output logic               out_rejected
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = (PROBES > 1) ? $clog2(PROBES) : 1;

  vbf_state_t state_r, state_nxt;
  logic [HASH_W-1:0] pos_r, pos_nxt;
  logic [HASH_W-1:0] stride_r, stride_nxt;
  logic              op_r, op_nxt;
  logic              rej_r, rej_nxt;
  logic [SETS-1:0]   set_bit_r, set_bit_nxt;
  logic [SETS-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              rv_r, rv_nxt;
  logic [AW-1:0]     raddr_r, raddr_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic [MATCH_W-1:0] out_match_r;
  logic               out_rej_r;

  logic               out_free;
  logic               in_acc;
  logic               in_reject;
  logic [SETS-1:0]    in_set_bit;
  logic [SETS-1:0]    acc_upd;
  logic [MATCH_W-1:0] lowest;
  logic               load_out;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [SETS-1:0] wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [SETS-1:0] rd_data;

  vbf_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));
  assign in_acc     = in_valid && !in_stall;
  assign in_reject  = (in_op == OP_ADD) &&
                      ((in_add_set == '0) || (32'(in_add_set) > 32'(SETS)));
  assign in_set_bit = SETS'(1) << (in_add_set - SET_W'(1));

  assign acc_upd = (rv_r && (op_r == OP_LOOKUP)) ? (acc_r & rd_data) : acc_r;

  always_comb begin
    lowest = '0;
    for (int i = SETS - 1; i >= 0; i--) begin
      if (acc_upd[i]) begin
        lowest = MATCH_W'(i + 1);
      end
    end
  end

  assign rd_en   = (state_r == ST_ISSUE);
  assign rd_addr = pos_r[AW-1:0];

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en   = rv_r && (op_r == OP_ADD);
      wr_addr = raddr_r;
      wr_data = rd_data | set_bit_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    stride_nxt  = stride_r;
    op_nxt      = op_r;
    rej_nxt     = rej_r;
    set_bit_nxt = set_bit_r;
    acc_nxt     = acc_upd;
    cnt_nxt     = cnt_r;
    rv_nxt      = 1'b0;
    raddr_nxt   = raddr_r;
    clr_nxt     = clr_r;
    load_out    = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_ISSUE: begin
        rv_nxt    = 1'b1;
        raddr_nxt = pos_r[AW-1:0];
        pos_nxt   = pos_r + stride_r;
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(PROBES - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (in_acc) begin
      op_nxt      = in_op;
      pos_nxt     = in_first_hash;
      stride_nxt  = in_second_hash;
      rej_nxt     = in_reject;
      set_bit_nxt = in_set_bit;
      acc_nxt     = '1;
      cnt_nxt     = '0;
      state_nxt   = in_reject ? ST_FIN : ST_ISSUE;
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    stride_r  <= stride_nxt;
    op_r      <= op_nxt;
    rej_r     <= rej_nxt;
    set_bit_r <= set_bit_nxt;
    acc_r     <= acc_nxt;
    cnt_r     <= cnt_nxt;
    raddr_r   <= raddr_nxt;
    if (load_out) begin
      out_hit_r   <= (op_r == OP_LOOKUP) && (acc_upd != '0);
      out_match_r <= (op_r == OP_LOOKUP) ? lowest : '0;
      out_rej_r   <= rej_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_match_set = out_match_r;
  assign out_rejected  = out_rej_r;

endmodule

/* sv/vbf_slot_ram.sv */
// vbf_slot_ram: slot store, one write port and one read port, registered read
// no dependencies
module vbf_slot_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/vbf_checker.sv */
// vbf_checker: port-level checks for the vector bloom filter, with its bind
// depends on vbf_pkg and the vector_bloom_filter_membership top level
module vbf_checker import vbf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_hit,
  input logic [MATCH_W-1:0] out_match_set,
  input logic               out_rejected
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_take && !out_take) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_take && out_take) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // clearing pass follows reset
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken straight after reset");

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |-> (pend_r != 2'd0))
    else $error("result with no request outstanding");

  // at most one request in work and one result waiting
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      ($stable(out_hit) && $stable(out_match_set) && $stable(out_rejected)))
    else $error("result changed while stalled");

endmodule

bind vector_bloom_filter_membership vbf_checker u_vbf_checker (.*);

/* test/vector_bloom_filter_membership_check.sv */
// vector_bloom_filter_membership_check: watches both channels of the bloom filter,
// predicts each result from its own copy of the slot store and compares in order
// depends on vbf_pkg
module vector_bloom_filter_membership_check import vbf_pkg::*; #(
  parameter int SLOTS  = 2048,
  parameter int PROBES = 4,
  parameter int SETS   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_op,
  input  logic [HASH_W-1:0]  in_first_hash,
  input  logic [HASH_W-1:0]  in_second_hash,
  input  logic [SET_W-1:0]   in_add_set,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic [MATCH_W-1:0] out_match_set,
  input  logic               out_rejected,
  output int                 pending,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               hit;
    logic [MATCH_W-1:0] match_set;
    logic               rejected;
  } bloom_result_t;

  logic [SETS-1:0] slot_bits [SLOTS];
  bloom_result_t   expected_results [$];

  function automatic bloom_result_t bloom_apply(input logic op, input logic [HASH_W-1:0] h1,
                                                input logic [HASH_W-1:0] h2,
                                                input logic [SET_W-1:0] set_id);
    bloom_result_t   res;
    logic [HASH_W-1:0] pos;
    logic [SETS-1:0] acc;
    int              j;
    int              idx;
    res = '0;
    if (op == OP_ADD) begin
      if (set_id == 0 || set_id > SETS) begin
        res.rejected = 1'b1;
      end else begin
        for (j = 0; j < PROBES; j++) begin
          pos = h1 + HASH_W'(j) * h2;
          slot_bits[pos % SLOTS][set_id - 1] = 1'b1;
        end
      end
    end else begin
      acc = '1;
      for (j = 0; j < PROBES; j++) begin
        pos = h1 + HASH_W'(j) * h2;
        acc &= slot_bits[pos % SLOTS];
      end
      if (acc != '0) begin
        res.hit = 1'b1;
        for (idx = SETS - 1; idx >= 0; idx--)
          if (acc[idx]) res.match_set = MATCH_W'(idx + 1);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    bloom_result_t got;
    bloom_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_bits[i] = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // result side first: a request taken at this edge cannot answer at it
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{hit: out_hit, match_set: out_match_set, rejected: out_rejected};
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result hit=%b match_set=%0d rejected=%b",
                     $realtime, got.hit, got.match_set, got.rejected);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit || got.match_set !== want.match_set ||
              got.rejected !== want.rejected) begin
            if (fail_count < 10)
              $display("%0t: expected hit=%b match=%0d rej=%b, got hit=%b match=%0d rej=%b",
                       $realtime, want.hit, want.match_set, want.rejected,
                       got.hit, got.match_set, got.rejected);
            fail_count++;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_results.push_back(bloom_apply(in_op, in_first_hash, in_second_hash,
                                               in_add_set));
    end
    pending = expected_results.size();
  end

endmodule

/* test/vector_bloom_filter_membership_test.sv */
// vector_bloom_filter_membership_test: stimulus and verdict for the bloom filter
// depends on vbf_pkg, vector_bloom_filter_membership and its checker module
module vector_bloom_filter_membership_test import vbf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int KEY_POOL    = 24;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_LOOKUP;
  logic [HASH_W-1:0]  in_first_hash = '0;
  logic [HASH_W-1:0]  in_second_hash = '0;
  logic [SET_W-1:0]   in_add_set = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic [MATCH_W-1:0] out_match_set;
  logic               out_rejected;

  int pending;
  int fail_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  logic [HASH_W-1:0] key_first  [KEY_POOL];
  logic [HASH_W-1:0] key_second [KEY_POOL];

  vector_bloom_filter_membership u_top (.*);

  vector_bloom_filter_membership_check u_check (.*);

  always #1 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic op, input logic [HASH_W-1:0] h1,
                              input logic [HASH_W-1:0] h2, input logic [SET_W-1:0] set_id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_first_hash  <= h1;
    in_second_hash <= h2;
    in_add_set     <= set_id;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random();
    int          pick;
    int          k;
    logic [SET_W-1:0] bad_set;
    pick = $urandom_range(99);
    k    = $urandom_range(KEY_POOL - 1);
    bad_set = ($urandom_range(1) == 0) ? SET_W'(0) : SET_W'($urandom_range(9, 15));
    if (pick < 40)
      send_request(OP_ADD, key_first[k], key_second[k], SET_W'($urandom_range(1, 8)));
    else if (pick < 48)
      send_request(OP_ADD, $urandom, $urandom, bad_set);
    else if (pick < 82)
      send_request(OP_LOOKUP, key_first[k], key_second[k], SET_W'($urandom));
    else
      send_request(OP_LOOKUP, $urandom, $urandom, SET_W'($urandom));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random();
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < KEY_POOL; i++) begin
      key_first[i]  = $urandom;
      key_second[i] = $urandom;
      // stride a multiple of the slot count, so every probe lands on one slot
      if (i % 6 == 0) key_second[i][10:0] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 81;

    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_0000, 4'h1);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 4'h0);
    send_request(OP_ADD,    32'hffff_ffff, 32'hffff_ffff, 4'h8);
    send_request(OP_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    send_request(OP_ADD,    32'h1234_5678, 32'h9abc_def1, 4'h0);
    send_request(OP_ADD,    32'h1234_5678, 32'h9abc_def1, 4'h9);
    send_request(OP_ADD,    32'h1234_5678, 32'h9abc_def1, 4'hf);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'h9abc_def1, 4'h3);
    send_request(OP_ADD,    32'h1234_5678, 32'h9abc_def1, 4'h5);
    send_request(OP_ADD,    32'h1234_5678, 32'h9abc_def1, 4'h2);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'h9abc_def1, 4'h0);
    send_request(OP_ADD,    32'h0000_0800, 32'h0000_0800, 4'h3);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 4'h8);
    send_request(OP_LOOKUP, 32'h0000_0800, 32'h0000_0800, 4'h1);
    send_request(OP_ADD,    32'h7fff_ffff, 32'h8000_0001, 4'h4);
    send_request(OP_LOOKUP, 32'h7fff_ffff, 32'h8000_0001, 4'h0);
    send_request(OP_LOOKUP, 32'haaaa_aaaa, 32'h5555_5555, 4'h0);
    send_request(OP_ADD,    32'haaaa_aaaa, 32'h5555_5555, 4'h7);
    send_request(OP_LOOKUP, 32'haaaa_aaaa, 32'h5555_5555, 4'hc);
    send_request(OP_LOOKUP, 32'haaaa_aaaa, 32'h5555_5554, 4'h0);
    drain_results();

    run_phase(37, 81, 310);
    run_phase(81, 37, 310);
    run_phase(0, 0, 310);

    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/vbf_pkg.sv
sv/vbf_slot_ram.sv
sv/vector_bloom_filter_membership.sv
sv/vbf_checker.sv
test/vector_bloom_filter_membership_check.sv
test/vector_bloom_filter_membership_test.sv
